// ----- rtl/gfp_pkg.sv -----
// Shared types and constants for the gradient file parser.
package gfp_pkg;

    // Record kinds
    localparam logic [2:0] KIND_VERSION = 3'd0;
    localparam logic [2:0] KIND_TITLE   = 3'd1;
    localparam logic [2:0] KIND_RGB     = 3'd2;
    localparam logic [2:0] KIND_OPACITY = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Error numbers
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_MAGIC     = 4'd1;
    localparam logic [3:0] ERR_RGB_CNT   = 4'd2;
    localparam logic [3:0] ERR_RGB_HEAD  = 4'd3;
    localparam logic [3:0] ERR_RGB_Z     = 4'd4;
    localparam logic [3:0] ERR_RGB_MID   = 4'd5;
    localparam logic [3:0] ERR_RGB_PAIR  = 4'd6;
    localparam logic [3:0] ERR_RGB_INIT  = 4'd7;
    localparam logic [3:0] ERR_OP_HDR    = 4'd8;
    localparam logic [3:0] ERR_OP_CNT    = 4'd9;

    // Opacity stop count above which the over-count warning is raised
    localparam logic [7:0] OP_WARN_COUNT = 8'd31;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  code;
        logic [7:0]  index;
        logic [15:0] position;
        logic [7:0]  midpoint;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  opacity;
        logic [15:0] smoothness;
        logic        last;
    } t_out_item;

    // File magic "8BGR"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0:    v = 8'h38;
            2'd1:    v = 8'h42;
            2'd2:    v = 8'h47;
            default: v = 8'h52;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/gradient_file_parser.sv -----
// Top level of the byte-serial gradient file parser.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one file byte
//   per item plus a start flag; a start flag of 1 restarts the parser and the
//   byte is taken as the first magic byte.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries at most
//   one record per input item: version, title byte, rgb stop, opacity stop
//   or error. An error record ends parsing until the next start flag.
// Timing:
//   One item per cycle while the input is not stalled. A record shows up on the output register in the
//   cycle after its input item is accepted; the whole byte update is one
//   pass of logic between the input port and the output register.
// Reset:
//   i_rst_n low clears the parser to the magic stage and empties the output
//   register.
// Stall:
//   While the output register holds a record and i_out_stall is high, the
//   input is stalled; otherwise a new item is taken even if a record is
//   being handed over in the same cycle.
module gradient_file_parser
    import gfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_VERSION = 4'd1,
        PH_TLEN    = 4'd2,
        PH_TITLE   = 4'd3,
        PH_RGBCNT  = 4'd4,
        PH_RGBSTOP = 4'd5,
        PH_OPHDR   = 4'd6,
        PH_OPSTOP  = 4'd7,
        PH_IDLE    = 4'd8
    } t_phase;

    // Parser state
    t_phase      r_phase,      n_phase;
    logic [4:0]  r_bpos,       n_bpos;
    logic [8:0]  r_remain,     n_remain;
    logic [7:0]  r_stop_total, n_stop_total;
    logic [7:0]  r_stop_num,   n_stop_num;
    logic [63:0] r_hold,       n_hold;
    logic [3:0]  r_pend,       n_pend;
    logic        r_bad_pad,    n_bad_pad;
    logic [7:0]  r_pair_first, n_pair_first;
    logic        r_pair_bad,   n_pair_bad;
    logic [3:0]  r_stop_fault, n_stop_fault;

    // Output register
    logic        r_out_valid;
    t_out_item   r_out_data;
    logic        n_emit;
    t_out_item   n_out;

    logic        w_accept;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Byte update: next state and record for the item at the input port
    always_comb begin
        logic [7:0]  b;
        logic [5:0]  e;
        logic [5:0]  i;
        logic        final_stop;
        logic [3:0]  f;
        logic [63:0] h;
        logic [7:0]  idx;
        logic [4:0]  bpos_inc;

        b = i_in_data.data_byte;

        // Start flag restarts the parser before the byte is taken
        if (i_in_data.start_req) begin
            n_phase      = PH_MAGIC;
            n_bpos       = '0;
            n_remain     = '0;
            n_stop_total = '0;
            n_stop_num   = '0;
            n_hold       = '0;
            n_pend       = ERR_NONE;
            n_bad_pad    = 1'b0;
            n_pair_first = '0;
            n_pair_bad   = 1'b0;
            n_stop_fault = ERR_NONE;
        end else begin
            n_phase      = r_phase;
            n_bpos       = r_bpos;
            n_remain     = r_remain;
            n_stop_total = r_stop_total;
            n_stop_num   = r_stop_num;
            n_hold       = r_hold;
            n_pend       = r_pend;
            n_bad_pad    = r_bad_pad;
            n_pair_first = r_pair_first;
            n_pair_bad   = r_pair_bad;
            n_stop_fault = r_stop_fault;
        end

        n_emit     = 1'b0;
        n_out      = '0;
        e          = {1'b0, n_bpos};
        i          = '0;
        final_stop = 1'b0;
        f          = ERR_NONE;
        h          = '0;
        idx        = '0;
        bpos_inc   = n_bpos + 5'd1;

        unique case (n_phase)
            PH_MAGIC: begin
                if (b != magic_byte(n_bpos[1:0])) begin
                    n_pend = ERR_MAGIC;
                end
                n_bpos = bpos_inc;
                if (bpos_inc >= 5'd4) begin
                    n_bpos = '0;
                    if (n_pend != ERR_NONE) begin
                        n_emit     = 1'b1;
                        n_out.kind = KIND_ERROR;
                        n_out.code = n_pend;
                        n_out.last = 1'b1;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_hold  = '0;
                        n_phase = PH_VERSION;
                    end
                end
            end

            PH_VERSION: begin
                n_hold = {32'd0, n_hold[23:0], b};
                n_bpos = bpos_inc;
                if (bpos_inc >= 5'd4) begin
                    n_emit           = 1'b1;
                    n_out.kind       = KIND_VERSION;
                    n_out.position   = n_hold[31:16];
                    n_out.smoothness = n_hold[15:0];
                    n_bpos           = '0;
                    n_hold           = '0;
                    n_phase          = PH_TLEN;
                end
            end

            PH_TLEN: begin
                n_remain   = {1'b0, b} + 9'd1;
                n_stop_num = '0;
                n_phase    = PH_TITLE;
            end

            PH_TITLE: begin
                n_emit      = 1'b1;
                n_out.kind  = KIND_TITLE;
                n_out.index = n_stop_num;
                n_out.red   = b;
                n_stop_num  = n_stop_num + 8'd1;
                n_remain    = n_remain - 9'd1;
                if (n_remain == 9'd0) begin
                    n_phase = PH_RGBCNT;
                end
            end

            PH_RGBCNT: begin
                if (b < 8'd2) begin
                    n_emit     = 1'b1;
                    n_out.kind = KIND_ERROR;
                    n_out.code = ERR_RGB_CNT;
                    n_out.last = 1'b1;
                    n_phase    = PH_IDLE;
                end else begin
                    n_stop_total = b;
                    n_stop_num   = '0;
                    n_pend       = ERR_NONE;
                    n_bpos       = '0;
                    n_hold       = '0;
                    n_pair_first = '0;
                    n_pair_bad   = 1'b0;
                    n_stop_fault = ERR_NONE;
                    n_bad_pad    = 1'b0;
                    n_phase      = PH_RGBSTOP;
                end
            end

            PH_RGBSTOP: begin
                // First stop has no z block: map onto the 20-byte layout
                if (n_stop_num == 8'd0 && e >= 6'd4) begin
                    e = e + 6'd4;
                end
                n_bpos = bpos_inc;
                i      = e - 6'd12;

                priority if (e <= 6'd1) begin
                    if (b != 8'd0 && n_stop_fault == ERR_NONE) n_stop_fault = ERR_RGB_HEAD;
                end else if (e == 6'd2) begin
                    n_hold[15:8] = n_hold[15:8] | b;
                end else if (e == 6'd3) begin
                    n_hold[7:0] = n_hold[7:0] | b;
                end else if (e <= 6'd5) begin
                    if (b != 8'd0 && n_stop_fault == ERR_NONE) n_stop_fault = ERR_RGB_Z;
                end else if (e == 6'd6) begin
                    n_hold[31:24] = n_hold[31:24] | b;
                end else if (e == 6'd7) begin
                    n_hold[23:16] = n_hold[23:16] | b;
                end else if (e <= 6'd10) begin
                    if (b != 8'd0 && n_stop_fault == ERR_NONE) n_stop_fault = ERR_RGB_MID;
                end else if (e == 6'd11) begin
                    n_hold[39:32] = n_hold[39:32] | b;
                end else begin
                    // Colour block: byte pairs, first pair must be zero
                    if (!i[0]) begin
                        n_pair_first = b;
                        if (i == 6'd2) n_hold[47:40] = n_hold[47:40] | b;
                        if (i == 6'd4) n_hold[55:48] = n_hold[55:48] | b;
                        if (i == 6'd6) n_hold[63:56] = n_hold[63:56] | b;
                    end else if (b != n_pair_first) begin
                        n_pair_bad = 1'b1;
                    end
                    if (i == 6'd0 && b != 8'd0) n_bad_pad = 1'b1;
                end

                // Stop complete
                if (e >= 6'd19) begin
                    if (n_stop_fault == ERR_NONE) begin
                        if (n_pair_bad) n_stop_fault = ERR_RGB_PAIR;
                        else if (n_bad_pad) n_stop_fault = ERR_RGB_INIT;
                    end
                    if (n_pend == ERR_NONE) n_pend = n_stop_fault;

                    final_stop = ({1'b0, n_stop_num} + 9'd1) >= {1'b0, n_stop_total};
                    idx        = n_stop_num;
                    f          = n_stop_fault;
                    h          = n_hold;

                    n_stop_num   = n_stop_num + 8'd1;
                    n_bpos       = '0;
                    n_hold       = '0;
                    n_pair_first = '0;
                    n_pair_bad   = 1'b0;
                    n_stop_fault = ERR_NONE;
                    n_bad_pad    = 1'b0;

                    if (final_stop && n_pend != ERR_NONE) begin
                        n_emit     = 1'b1;
                        n_out.kind = KIND_ERROR;
                        n_out.code = n_pend;
                        n_out.last = 1'b1;
                        n_phase    = PH_IDLE;
                    end else begin
                        if (final_stop) n_phase = PH_OPHDR;
                        if (f == ERR_NONE) begin
                            n_emit           = 1'b1;
                            n_out.kind       = KIND_RGB;
                            n_out.index      = idx;
                            n_out.position   = h[31:16];
                            n_out.midpoint   = h[39:32];
                            n_out.red        = h[47:40];
                            n_out.green      = h[55:48];
                            n_out.blue       = h[63:56];
                            n_out.smoothness = h[15:0];
                        end
                    end
                end
            end

            PH_OPHDR: begin
                if (n_bpos < 5'd5) begin
                    if (b != 8'd0) n_pend = ERR_OP_HDR;
                    n_bpos = bpos_inc;
                end else if (n_pend != ERR_NONE) begin
                    n_emit     = 1'b1;
                    n_out.kind = KIND_ERROR;
                    n_out.code = n_pend;
                    n_out.last = 1'b1;
                    n_phase    = PH_IDLE;
                end else if (b < 8'd2) begin
                    n_emit     = 1'b1;
                    n_out.kind = KIND_ERROR;
                    n_out.code = ERR_OP_CNT;
                    n_out.last = 1'b1;
                    n_phase    = PH_IDLE;
                end else begin
                    n_stop_total = b;
                    n_stop_num   = '0;
                    n_bpos       = '0;
                    n_hold       = '0;
                    n_pair_first = '0;
                    n_pair_bad   = 1'b0;
                    n_stop_fault = ERR_NONE;
                    n_bad_pad    = 1'b0;
                    n_phase      = PH_OPSTOP;
                end
            end

            PH_OPSTOP: begin
                n_bpos = bpos_inc;
                priority if (e == 6'd2) begin
                    n_hold[7:0] = n_hold[7:0] | b;
                end else if (e == 6'd7) begin
                    n_hold[15:8] = n_hold[15:8] | b;
                end else if (e == 6'd9) begin
                    n_hold[23:16] = n_hold[23:16] | b;
                end else if (b != 8'd0) begin
                    n_bad_pad = 1'b1;
                end

                if (e >= 6'd9) begin
                    n_emit         = 1'b1;
                    n_out.kind     = KIND_OPACITY;
                    n_out.code     = {2'b00, (n_stop_total > OP_WARN_COUNT), n_bad_pad};
                    n_out.index    = n_stop_num;
                    n_out.position = {8'd0, n_hold[7:0]};
                    n_out.midpoint = n_hold[15:8];
                    n_out.opacity  = n_hold[23:16];
                    if (({1'b0, n_stop_num} + 9'd1) >= {1'b0, n_stop_total}) begin
                        n_out.last = 1'b1;
                        n_phase    = PH_IDLE;
                    end
                    n_stop_num   = n_stop_num + 8'd1;
                    n_bpos       = '0;
                    n_hold       = '0;
                    n_pair_first = '0;
                    n_pair_bad   = 1'b0;
                    n_stop_fault = ERR_NONE;
                    n_bad_pad    = 1'b0;
                end
            end

            default: begin
                // Done or failed: bytes are dropped until the next start flag
            end
        endcase
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC;
            r_bpos       <= '0;
            r_remain     <= '0;
            r_stop_total <= '0;
            r_stop_num   <= '0;
            r_hold       <= '0;
            r_pend       <= ERR_NONE;
            r_bad_pad    <= 1'b0;
            r_pair_first <= '0;
            r_pair_bad   <= 1'b0;
            r_stop_fault <= ERR_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase      <= n_phase;
                r_bpos       <= n_bpos;
                r_remain     <= n_remain;
                r_stop_total <= n_stop_total;
                r_stop_num   <= n_stop_num;
                r_hold       <= n_hold;
                r_pend       <= n_pend;
                r_bad_pad    <= n_bad_pad;
                r_pair_first <= n_pair_first;
                r_pair_bad   <= n_pair_bad;
                r_stop_fault <= n_stop_fault;
                r_out_valid  <= n_emit;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Record payload; loaded only when a new item is taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out;
        end
    end

endmodule

// ----- dv/gfp_record_checker.sv -----
`timescale 1ns / 100ps
// Record checker for the gradient file parser: byte-level prediction and record compare.
module gfp_record_checker
    import gfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam logic [31:0] FILE_MAGIC = 32'h3842_4752;  // "8BGR"

    typedef enum logic [3:0] {
        ST_MAGIC,
        ST_VERSION,
        ST_TLEN,
        ST_TITLE,
        ST_RGBCNT,
        ST_RGBSTOP,
        ST_OPHDR,
        ST_OPSTOP,
        ST_DONE
    } t_parse_stage;

    // Shadow parser state
    t_parse_stage stage;
    logic [4:0]   byte_pos;
    logic [8:0]   bytes_left;
    logic [7:0]   stop_count;
    logic [7:0]   stop_idx;
    logic [63:0]  held;
    logic [3:0]   held_fault;
    logic         pad_nonzero;
    logic [7:0]   pair_lead;
    logic         pair_mismatch;
    logic [3:0]   stop_fault;

    // Record produced by the current item, if any
    t_out_item    rec_out;
    logic         rec_ready;

    t_out_item    records_due[$];
    int           mismatches = 0;
    int           awaited = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = awaited;

    task automatic reset_parser();
        stage         = ST_MAGIC;
        byte_pos      = '0;
        bytes_left    = '0;
        stop_count    = '0;
        stop_idx      = '0;
        held          = '0;
        held_fault    = ERR_NONE;
        pad_nonzero   = 1'b0;
        pair_lead     = '0;
        pair_mismatch = 1'b0;
        stop_fault    = ERR_NONE;
    endtask

    // Per-stop scratch cleared at each stop boundary
    task automatic clear_stop();
        byte_pos      = '0;
        held          = '0;
        pair_lead     = '0;
        pair_mismatch = 1'b0;
        stop_fault    = ERR_NONE;
        pad_nonzero   = 1'b0;
    endtask

    // Only the first fault within a stop is kept
    task automatic note_fault(input logic [3:0] f);
        if (stop_fault == ERR_NONE) stop_fault = f;
    endtask

    task automatic raise_error(input logic [3:0] c);
        rec_out      = '0;
        rec_out.kind = KIND_ERROR;
        rec_out.code = c;
        rec_out.last = 1'b1;
        rec_ready    = 1'b1;
        stage        = ST_DONE;
    endtask

    // One byte of an rgb stop; offsets follow the 20-byte layout
    task automatic take_rgb_byte(input logic [7:0] b);
        int          e;
        int          i;
        logic        final_stop;
        logic [7:0]  idx;
        logic [3:0]  f;
        logic [63:0] h;
        e = int'(byte_pos);
        // first stop has no z block
        if (stop_idx == 8'd0 && e >= 4) e = e + 4;
        byte_pos = byte_pos + 5'd1;

        if (e <= 1) begin
            if (b != 8'd0) note_fault(ERR_RGB_HEAD);
        end else if (e == 2) begin
            held[15:8] = b;
        end else if (e == 3) begin
            held[7:0] = b;
        end else if (e <= 5) begin
            if (b != 8'd0) note_fault(ERR_RGB_Z);
        end else if (e == 6) begin
            held[31:24] = b;
        end else if (e == 7) begin
            held[23:16] = b;
        end else if (e <= 10) begin
            if (b != 8'd0) note_fault(ERR_RGB_MID);
        end else if (e == 11) begin
            held[39:32] = b;
        end else begin
            // colour block: byte pairs, the first pair must be zero
            i = e - 12;
            if (i % 2 == 0) begin
                pair_lead = b;
                if (i == 2) held[47:40] = b;
                if (i == 4) held[55:48] = b;
                if (i == 6) held[63:56] = b;
            end else if (b != pair_lead) begin
                pair_mismatch = 1'b1;
            end
            if (i == 0 && b != 8'd0) pad_nonzero = 1'b1;
        end
        if (e < 19) return;

        if (pair_mismatch) note_fault(ERR_RGB_PAIR);
        else if (pad_nonzero) note_fault(ERR_RGB_INIT);
        if (held_fault == ERR_NONE) held_fault = stop_fault;

        final_stop = ({1'b0, stop_idx} + 9'd1) >= {1'b0, stop_count};
        idx = stop_idx;
        f   = stop_fault;
        h   = held;
        stop_idx = stop_idx + 8'd1;
        clear_stop();
        if (final_stop) begin
            // a held fault replaces the last stop's record
            if (held_fault != ERR_NONE) begin
                raise_error(held_fault);
                return;
            end
            stage = ST_OPHDR;
        end
        if (f != ERR_NONE) return;
        rec_out            = '0;
        rec_out.kind       = KIND_RGB;
        rec_out.index      = idx;
        rec_out.position   = h[31:16];
        rec_out.midpoint   = h[39:32];
        rec_out.red        = h[47:40];
        rec_out.green      = h[55:48];
        rec_out.blue       = h[63:56];
        rec_out.smoothness = h[15:0];
        rec_ready          = 1'b1;
    endtask

    // One byte of a 10-byte opacity stop
    task automatic take_opacity_byte(input logic [7:0] b);
        int e;
        e = int'(byte_pos);
        byte_pos = byte_pos + 5'd1;
        if (e == 2) held[7:0] = b;
        else if (e == 7) held[15:8] = b;
        else if (e == 9) held[23:16] = b;
        else if (b != 8'd0) pad_nonzero = 1'b1;
        if (e < 9) return;

        rec_out          = '0;
        rec_out.kind     = KIND_OPACITY;
        rec_out.code     = {2'b00, stop_count > OP_WARN_COUNT, pad_nonzero};
        rec_out.index    = stop_idx;
        rec_out.position = {8'd0, held[7:0]};
        rec_out.midpoint = held[15:8];
        rec_out.opacity  = held[23:16];
        if (({1'b0, stop_idx} + 9'd1) >= {1'b0, stop_count}) begin
            rec_out.last = 1'b1;
            stage        = ST_DONE;
        end
        stop_idx  = stop_idx + 8'd1;
        clear_stop();
        rec_ready = 1'b1;
    endtask

    // Advance the shadow parser by one accepted item
    task automatic parse_byte(input t_in_item it);
        logic [7:0] b;
        b = it.data_byte;
        rec_ready = 1'b0;
        if (it.start_req) reset_parser();

        case (stage)
            ST_MAGIC: begin
                // mismatch is only reported once all four bytes are in
                if (b != FILE_MAGIC[8 * (3 - byte_pos[1:0]) +: 8]) held_fault = ERR_MAGIC;
                byte_pos = byte_pos + 5'd1;
                if (byte_pos == 5'd4) begin
                    byte_pos = '0;
                    if (held_fault != ERR_NONE) begin
                        raise_error(held_fault);
                    end else begin
                        held  = '0;
                        stage = ST_VERSION;
                    end
                end
            end
            ST_VERSION: begin
                held = {32'd0, held[23:0], b};
                byte_pos = byte_pos + 5'd1;
                if (byte_pos == 5'd4) begin
                    rec_out            = '0;
                    rec_out.kind       = KIND_VERSION;
                    rec_out.position   = held[31:16];
                    rec_out.smoothness = held[15:0];
                    rec_ready          = 1'b1;
                    byte_pos           = '0;
                    held               = '0;
                    stage              = ST_TLEN;
                end
            end
            ST_TLEN: begin
                bytes_left = {1'b0, b} + 9'd1;
                stop_idx   = '0;
                stage      = ST_TITLE;
            end
            ST_TITLE: begin
                rec_out       = '0;
                rec_out.kind  = KIND_TITLE;
                rec_out.index = stop_idx;
                rec_out.red   = b;
                rec_ready     = 1'b1;
                stop_idx      = stop_idx + 8'd1;
                bytes_left    = bytes_left - 9'd1;
                if (bytes_left == 9'd0) stage = ST_RGBCNT;
            end
            ST_RGBCNT: begin
                if (b < 8'd2) begin
                    raise_error(ERR_RGB_CNT);
                end else begin
                    stop_count = b;
                    stop_idx   = '0;
                    held_fault = ERR_NONE;
                    clear_stop();
                    stage      = ST_RGBSTOP;
                end
            end
            ST_RGBSTOP: take_rgb_byte(b);
            ST_OPHDR: begin
                if (byte_pos < 5'd5) begin
                    if (b != 8'd0) held_fault = ERR_OP_HDR;
                    byte_pos = byte_pos + 5'd1;
                end else if (held_fault != ERR_NONE) begin
                    raise_error(held_fault);
                end else if (b < 8'd2) begin
                    raise_error(ERR_OP_CNT);
                end else begin
                    stop_count = b;
                    stop_idx   = '0;
                    clear_stop();
                    stage      = ST_OPSTOP;
                end
            end
            ST_OPSTOP: take_opacity_byte(b);
            default: ;
        endcase

        if (rec_ready) records_due.push_back(rec_out);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_record(input t_out_item got);
        t_out_item want;
        if (records_due.size() == 0) begin
            $error("record with none due: kind %0d code %0d", got.kind, got.code);
            mismatches++;
            return;
        end
        want = records_due.pop_front();
        check_field("kind",       16'(want.kind),   16'(got.kind));
        check_field("code",       16'(want.code),   16'(got.code));
        check_field("index",      16'(want.index),  16'(got.index));
        check_field("position",   want.position,    got.position);
        check_field("midpoint",   16'(want.midpoint), 16'(got.midpoint));
        check_field("red",        16'(want.red),    16'(got.red));
        check_field("green",      16'(want.green),  16'(got.green));
        check_field("blue",       16'(want.blue),   16'(got.blue));
        check_field("opacity",    16'(want.opacity), 16'(got.opacity));
        check_field("smoothness", want.smoothness,  got.smoothness);
        check_field("last",       16'(want.last),   16'(got.last));
    endtask

    // Records leaving at this edge come from earlier items: compare first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
            records_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) compare_record(i_out_data);
            if (i_in_valid && !i_in_stall) parse_byte(i_in_data);
        end
        awaited <= records_due.size();
    end

endmodule

// ----- dv/gradient_file_parser_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the gradient file parser: file stimulus, idling phases and verdict.
module gradient_file_parser_test;
    import gfp_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 180;
    localparam logic [31:0] FILE_MAGIC   = 32'h3842_4752;  // "8BGR"

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int files_sent  = 0;
    int bytes_sent  = 0;

    // Byte image of the file being sent, with offsets of its stop lists
    logic [7:0] file_bytes[$];
    int         rgb_base;
    int         op_base;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    gradient_file_parser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    gfp_record_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver back-pressure
    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [7:0] pad_byte(input int pct);
        logic [7:0] v;
        v = 8'd0;
        if ($urandom_range(99) < pct) v = 8'($urandom_range(255, 1));
        return v;
    endfunction

    function automatic int rgb_at(input int k);
        return rgb_base + ((k == 0) ? 0 : 16 + 20 * (k - 1));
    endfunction

    // Well-formed file with random content
    task automatic build_file(input int title_len, input int n_rgb, input int n_op,
                              input int pad_pct);
        logic [7:0] c;
        file_bytes.delete();
        for (int k = 0; k < 4; k++) file_bytes.push_back(FILE_MAGIC[8 * (3 - k) +: 8]);
        repeat (4) file_bytes.push_back(8'($urandom_range(255)));
        file_bytes.push_back(title_len[7:0]);
        repeat (title_len + 1) file_bytes.push_back(8'($urandom_range(255)));
        file_bytes.push_back(n_rgb[7:0]);
        rgb_base = file_bytes.size();
        for (int k = 0; k < n_rgb; k++) begin
            // head, z (not on the first stop), midpoint, colour pairs
            file_bytes.push_back(8'd0);
            file_bytes.push_back(8'd0);
            repeat (2) file_bytes.push_back(8'($urandom_range(255)));
            if (k > 0) begin
                file_bytes.push_back(8'd0);
                file_bytes.push_back(8'd0);
                repeat (2) file_bytes.push_back(8'($urandom_range(255)));
            end
            repeat (3) file_bytes.push_back(8'd0);
            file_bytes.push_back(8'($urandom_range(255)));
            file_bytes.push_back(8'd0);
            file_bytes.push_back(8'd0);
            repeat (3) begin
                c = 8'($urandom_range(255));
                file_bytes.push_back(c);
                file_bytes.push_back(c);
            end
        end
        op_base = file_bytes.size();
        repeat (5) file_bytes.push_back(8'd0);
        file_bytes.push_back(n_op[7:0]);
        repeat (n_op) begin
            file_bytes.push_back(pad_byte(pad_pct));
            file_bytes.push_back(pad_byte(pad_pct));
            file_bytes.push_back(8'($urandom_range(255)));
            repeat (4) file_bytes.push_back(pad_byte(pad_pct));
            file_bytes.push_back(8'($urandom_range(255)));
            file_bytes.push_back(pad_byte(pad_pct));
            file_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // One item through the handshake, after a random idle gap
    task automatic send_byte(input logic [7:0] b, input logic s);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, s};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // First count bytes of the file image; idling phase turns every three files
    task automatic send_file(input int count);
        files_sent++;
        case ((files_sent / 3) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 27; stall_pct = 27; end
        endcase
        for (int k = 0; k < count; k++) send_byte(file_bytes[k], k == 0);
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    endtask

    // Hold the sender until every due record has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int pick;
        int first;
        int idx;
        int tl;
        int nop;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Minimal good file, version halves at maximum
        build_file(0, 2, 2, 0);
        for (int k = 4; k < 8; k++) file_bytes[k] = 8'hFF;
        send_file(file_bytes.size());

        // Longest title and over 31 opacity stops, some nonzero padding;
        // only the first three opacity stops go out
        build_file(255, 3, 32, 20);
        send_file(op_base + 36);

        // Bad magic: reported on the fourth byte, rest ignored
        build_file(1, 2, 2, 0);
        file_bytes[2] = 8'h00;
        send_file(8);

        // Too few rgb stops
        build_file(1, 2, 2, 0);
        file_bytes[rgb_base - 1] = 8'd0;
        send_file(rgb_base + 2);
        build_file(0, 2, 2, 0);
        file_bytes[rgb_base - 1] = 8'd1;
        send_file(rgb_base + 2);

        // Nonzero head in the first stop, held to the last stop
        build_file(1, 3, 2, 0);
        file_bytes[rgb_at(0) + 1] = 8'h01;
        send_file(op_base);

        // Nonzero z prefix in a later stop
        build_file(1, 3, 2, 0);
        file_bytes[rgb_at(1) + 5] = 8'h80;
        send_file(op_base);

        // Nonzero midpoint prefix in the first stop
        build_file(0, 2, 2, 0);
        file_bytes[rgb_at(0) + 6] = 8'h10;
        send_file(op_base);

        // Differing pair beats nonzero initial pair, on the last stop
        build_file(2, 3, 2, 0);
        file_bytes[rgb_at(2) + 12] = 8'h01;
        file_bytes[rgb_at(2) + 17] = ~file_bytes[rgb_at(2) + 16];
        send_file(op_base);

        // Nonzero but matching initial pair
        build_file(1, 3, 2, 0);
        file_bytes[rgb_at(1) + 12] = 8'h03;
        file_bytes[rgb_at(1) + 13] = 8'h03;
        send_file(op_base);

        // Two faulty stops: the first one's fault is reported
        build_file(0, 4, 2, 0);
        file_bytes[rgb_at(0) + 4] = 8'h01;
        file_bytes[rgb_at(1)]     = 8'h01;
        send_file(op_base);

        // Opacity header not zero
        build_file(1, 2, 2, 0);
        file_bytes[op_base + 4] = 8'h01;
        send_file(op_base + 8);

        // Too few opacity stops
        build_file(1, 2, 2, 0);
        file_bytes[op_base + 5] = 8'd1;
        send_file(op_base + 8);
        build_file(0, 2, 2, 0);
        file_bytes[op_base + 5] = 8'd0;
        send_file(op_base + 8);

        // Padding warning on an opacity stop
        build_file(1, 2, 3, 0);
        file_bytes[op_base + 6 + 8] = 8'hFF;
        send_file(file_bytes.size());

        // Restart in the middle of a file
        build_file(3, 3, 3, 0);
        send_file(file_bytes.size() / 2);
        build_file(2, 2, 2, 0);
        send_file(file_bytes.size());

        // Bytes after a finished file are ignored
        repeat (6) send_byte(8'($urandom_range(255)), 1'b0);

        drain();

        // Random files: mostly well-formed, some corrupted, truncated or noise
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            tl   = ($urandom_range(19) == 0) ? $urandom_range(64) : $urandom_range(4);
            nop  = ($urandom_range(19) == 0) ? $urandom_range(34, 30) : $urandom_range(5, 2);
            build_file(tl, $urandom_range(5, 2), nop, 5);
            if (pick < 70) begin
                send_file(file_bytes.size());
            end else if (pick < 88) begin
                idx = $urandom_range(file_bytes.size() - 1);
                file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(7));
                send_file(file_bytes.size());
            end else if (pick < 95) begin
                send_file($urandom_range(file_bytes.size() - 1, 1));
            end else begin
                send_noise(24);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
